// ----- hw/rtl/i2r_pkg.sv -----
// Package for the integer to Roman numeral converter: types, constants and symbol tables.
package i2r_pkg;

    localparam logic [15:0] ROMAN_LIMIT = 16'd3999;
    localparam logic [2:0]  BIG_LAST_K  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_START,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        SEG_SIGN,
        SEG_THOU,
        SEG_HUND,
        SEG_TENS,
        SEG_UNIT,
        SEG_NONE
    } seg_t;

    typedef struct packed {
        logic load;
        logic split;
        logic start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic split_done;
        logic char_last;
    } sts_t;

    function automatic logic [7:0] roman_sym(input logic [2:0] idx);
        logic [7:0] sym;
        unique case (idx)
            3'd0:    sym = 8'h49; // I
            3'd1:    sym = 8'h56; // V
            3'd2:    sym = 8'h58; // X
            3'd3:    sym = 8'h4C; // L
            3'd4:    sym = 8'h43; // C
            3'd5:    sym = 8'h44; // D
            default: sym = 8'h4D; // M
        endcase
        return sym;
    endfunction

    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] len;
        unique case (d) inside
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    // Offset within a one/five/ten group for character k of a digit's pattern
    function automatic logic [1:0] digit_off(input logic [3:0] d, input logic [1:0] k);
        logic [1:0] off;
        off = 2'd0;
        if (k == 2'd0) begin
            unique case (d) inside
                4'd5, 4'd6, 4'd7, 4'd8: off = 2'd1;
                default:                off = 2'd0;
            endcase
        end
        else if (k == 2'd1) begin
            unique case (d) inside
                4'd4:    off = 2'd1;
                4'd9:    off = 2'd2;
                default: off = 2'd0;
            endcase
        end
        return off;
    endfunction

    function automatic logic [7:0] big_char(input logic [2:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'h42; // B
            3'd1:    ch = 8'h69; // i
            3'd2:    ch = 8'h67; // g
            3'd3:    ch = 8'h20; // space
            3'd4:    ch = 8'h6F; // o
            3'd5:    ch = 8'h6E; // n
            default: ch = 8'h65; // e
        endcase
        return ch;
    endfunction

endpackage

// ----- hw/rtl/integer_to_roman_numeral.sv -----
// Top level of the integer to Roman numeral converter.
//
//  channel  valid      stall      payload
//  input    in_valid   in_stall   value (signed 16 bits)
//  output   out_valid  out_stall  char_code (8 bits), last
//
// An item of n characters (n from 1 to 16) takes a load step, four digit split
// steps through the shared compare/subtract unit, a start step, then one
// character per cycle into the output register while the output is not stalled.
// Reset clears the controller and the output valid flag; no clearing pass.
// A stalled output holds the character; the next input is taken once the
// last character is in the output register.
module integer_to_roman_numeral (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         char_code,
    output logic               last
);

    i2r_pkg::cmd_t cmd;
    i2r_pkg::sts_t sts;

    i2r_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    i2r_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .char_code (char_code),
        .last      (last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in progress");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.char_last) |=> (!in_stall && out_valid && last))
        else $error("controller not idle after final character");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.split, cmd.start, cmd.emit}))
        else $error("more than one datapath command");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (char_code == 8'd0)) |-> last)
        else $error("empty string marker without last");

endmodule

// ----- hw/rtl/i2r_ctrl.sv -----
// Controller state machine and output valid flag for the Roman numeral converter.
module i2r_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output i2r_pkg::cmd_t cmd,
    input  i2r_pkg::sts_t sts
);

    i2r_pkg::state_t state_reg;
    i2r_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != i2r_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2r_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            i2r_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = i2r_pkg::ST_SPLIT;
                end
            end
            i2r_pkg::ST_SPLIT:
            begin
                cmd.split = 1'b1;
                if (sts.split_done)
                    state_next = i2r_pkg::ST_START;
            end
            i2r_pkg::ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = i2r_pkg::ST_EMIT;
            end
            i2r_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.char_last)
                        state_next = i2r_pkg::ST_IDLE;
                end
            end
            default:
                state_next = i2r_pkg::ST_IDLE;
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

endmodule

// ----- hw/rtl/i2r_dp.sv -----
// Datapath: magnitude capture, decimal digit split and character generation.
module i2r_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] value,
    input  i2r_pkg::cmd_t      cmd,
    output i2r_pkg::sts_t      sts,
    output logic [7:0]         char_code,
    output logic               last
);

    logic             neg_reg;
    logic             big_reg;
    logic             zero_reg;
    logic [11:0]      rem_reg;
    logic [11:0]      rem_next;
    logic [1:0]       pos_reg;
    logic [3:0]       dig_reg [4];
    i2r_pkg::seg_t    seg_reg;
    i2r_pkg::seg_t    seg_next;
    logic [2:0]       k_reg;
    logic [2:0]       k_next;
    logic [7:0]       char_code_reg;
    logic             last_reg;

    logic [15:0]      raw;
    logic [15:0]      mag;
    logic [13:0]      scale;
    logic [13:0]      rem_ext;
    logic [3:0]       dig;
    logic [13:0]      prod;
    logic [2:0]       seg_len [5];
    logic [4:0]       seg_ne;
    i2r_pkg::seg_t    first_seg;
    i2r_pkg::seg_t    after_seg;
    logic [2:0]       cur_len;
    logic [3:0]       cur_dig;
    logic [2:0]       sym_base;
    logic             cur_end;
    logic [7:0]       ch;
    logic             ch_last;

    function automatic i2r_pkg::seg_t first_from(input logic [2:0] start,
                                                 input logic [4:0] ne);
        i2r_pkg::seg_t res;
        res = i2r_pkg::SEG_NONE;
        for (int i = 4; i >= 0; i--)
        begin
            if ((3'(i) >= start) && ne[i])
                res = i2r_pkg::seg_t'(3'(i));
        end
        return res;
    endfunction

    assign raw = value;
    assign mag = raw[15] ? (~raw + 16'd1) : raw;

    // one decimal digit a cycle, thousands first
    always_comb
    begin
        unique case (pos_reg)
            2'd0:    scale = 14'd1000;
            2'd1:    scale = 14'd100;
            2'd2:    scale = 14'd10;
            default: scale = 14'd1;
        endcase
        rem_ext = {2'b00, rem_reg};
        dig     = 4'd0;
        for (int j = 1; j <= 9; j++)
        begin
            if (rem_ext >= 14'(14'(j) * scale))
                dig = 4'(j);
        end
        prod     = 14'(scale * {10'd0, dig});
        rem_next = 12'(rem_ext - prod);
    end

    always_comb
    begin
        seg_len[0] = {2'b00, neg_reg};
        seg_len[1] = dig_reg[0][2:0];
        seg_len[2] = i2r_pkg::digit_len(dig_reg[1]);
        seg_len[3] = i2r_pkg::digit_len(dig_reg[2]);
        seg_len[4] = i2r_pkg::digit_len(dig_reg[3]);
        for (int i = 0; i < 5; i++)
            seg_ne[i] = (seg_len[i] != 3'd0);
        first_seg = first_from(3'd0, seg_ne);
        after_seg = first_from(3'(seg_reg) + 3'd1, seg_ne);
    end

    always_comb
    begin
        cur_len  = 3'd0;
        cur_dig  = 4'd0;
        sym_base = 3'd0;
        unique case (seg_reg)
            i2r_pkg::SEG_SIGN: cur_len = seg_len[0];
            i2r_pkg::SEG_THOU: cur_len = seg_len[1];
            i2r_pkg::SEG_HUND:
            begin
                cur_len  = seg_len[2];
                cur_dig  = dig_reg[1];
                sym_base = 3'd4;
            end
            i2r_pkg::SEG_TENS:
            begin
                cur_len  = seg_len[3];
                cur_dig  = dig_reg[2];
                sym_base = 3'd2;
            end
            i2r_pkg::SEG_UNIT:
            begin
                cur_len  = seg_len[4];
                cur_dig  = dig_reg[3];
                sym_base = 3'd0;
            end
            default: cur_len = 3'd0;
        endcase
        cur_end = (k_reg == (cur_len - 3'd1));

        if (big_reg)
        begin
            ch      = i2r_pkg::big_char(k_reg);
            ch_last = (k_reg == i2r_pkg::BIG_LAST_K);
        end
        else if (zero_reg)
        begin
            ch      = 8'd0;
            ch_last = 1'b1;
        end
        else
        begin
            unique case (seg_reg)
                i2r_pkg::SEG_SIGN: ch = 8'h2D; // '-'
                i2r_pkg::SEG_THOU: ch = 8'h4D; // 'M'
                default:
                    ch = i2r_pkg::roman_sym(sym_base +
                         {1'b0, i2r_pkg::digit_off(cur_dig, k_reg[1:0])});
            endcase
            ch_last = cur_end && (after_seg == i2r_pkg::SEG_NONE);
        end

        seg_next = seg_reg;
        k_next   = k_reg;
        if (cmd.start)
        begin
            seg_next = first_seg;
            k_next   = 3'd0;
        end
        else if (cmd.emit)
        begin
            if (!big_reg && cur_end)
            begin
                seg_next = after_seg;
                k_next   = 3'd0;
            end
            else
                k_next = k_reg + 3'd1;
        end
    end

    assign sts.split_done = (pos_reg == 2'd3);
    assign sts.char_last  = ch_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            seg_reg <= i2r_pkg::SEG_NONE;
            k_reg   <= 3'd0;
        end
        else
        begin
            seg_reg <= seg_next;
            k_reg   <= k_next;
            if (cmd.load)
                pos_reg <= 2'd0;
            else if (cmd.split)
                pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= raw[15];
            big_reg  <= (mag >= i2r_pkg::ROMAN_LIMIT);
            zero_reg <= (mag == 16'd0);
            rem_reg  <= mag[11:0];
        end
        else if (cmd.split)
        begin
            dig_reg[pos_reg] <= dig;
            rem_reg          <= rem_next;
        end
        if (cmd.emit)
        begin
            char_code_reg <= ch;
            last_reg      <= ch_last;
        end
    end

    assign char_code = char_code_reg;
    assign last      = last_reg;

endmodule

// ----- test/testbench.sv -----
// Testbench for the integer to Roman numeral converter: directed, random, back-pressure and steady-flow tests.
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        int         src;
    } glyph_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [7:0]         char_code;
    logic               last;

    logic hold_off = 1'b0;
    logic in_idle_en = 1'b0;
    logic out_idle_en = 1'b0;

    glyph_t roman_q[$];
    int     errors = 0;
    int     items_sent = 0;
    int     glyphs_checked = 0;
    int     big_items = 0;
    int     neg_items = 0;
    int     zero_items = 0;
    int     stall_left = 0;
    int     quiet_cycles = 0;

    integer_to_roman_numeral dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void add_digit(ref byte unsigned text[$], input int d,
                                      input byte unsigned one, input byte unsigned five,
                                      input byte unsigned ten);
        if (d == 9)
        begin
            text.push_back(one);
            text.push_back(ten);
        end
        else if (d == 4)
        begin
            text.push_back(one);
            text.push_back(five);
        end
        else
        begin
            if (d >= 5)
                text.push_back(five);
            repeat (d % 5) text.push_back(one);
        end
    endfunction

    function automatic void predict_numeral(input logic signed [15:0] v);
        byte unsigned text[$];
        string        big_str;
        int           mag;
        glyph_t       g;
        big_str = "Big one";
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag >= int'(i2r_pkg::ROMAN_LIMIT))
        begin
            for (int i = 0; i < big_str.len(); i++)
                text.push_back(big_str[i]);
        end
        else
        begin
            if (v < 0)
                text.push_back("-");
            repeat (mag / 1000) text.push_back("M");
            add_digit(text, (mag / 100) % 10, "C", "D", "M");
            add_digit(text, (mag / 10) % 10, "X", "L", "C");
            add_digit(text, mag % 10, "I", "V", "X");
        end
        g.src = int'(v);
        if (text.size() == 0)
        begin
            g.ch = 8'h00;
            g.last = 1'b1;
            roman_q.push_back(g);
        end
        else
        begin
            foreach (text[i])
            begin
                g.ch = text[i];
                g.last = (i == text.size() - 1);
                roman_q.push_back(g);
            end
        end
    endfunction

    // Leaves in_valid high on return, unless a random idle gap is inserted, so back-to-back transfers need no re-assert
    task automatic send_value(input logic signed [15:0] v);
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_numeral(v);
        items_sent++;
        if (v == 0)
            zero_items++;
        else if (v < 0)
            neg_items++;
        if (v >= 3999 || v <= -3999)
            big_items++;
        if (in_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] random_value();
        logic signed [15:0] v;
        if ($urandom_range(0, 9) < 7)
        begin
            v = 16'($urandom_range(0, 3998));
            if ($urandom_range(0, 1))
                v = -v;
        end
        else
            v = 16'($urandom());
        return v;
    endfunction

    task automatic test_directed();
        logic signed [15:0] vals[$];
        vals = '{0, 1, -1, 4, 5, 9, 10, 14, 40, 49, 90, 99, 400, 444, 500, 900,
                 1994, 3888, -3888, 3998, -3998, 3999, -3999, 32767, -32768};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (12) send_value(random_value());
            end
        join
    endtask

    task automatic test_steady(input int count);
        in_idle_en <= 1'b0;
        out_idle_en <= 1'b0;
        repeat (count) send_value(random_value());
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (out_idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        out_stall <= hold_off || (stall_left > 0);
    end

    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (roman_q.size() == 0)
                report_error($sformatf("unexpected transfer: char 0x%02h last %0b",
                                       char_code, last));
            else
            begin
                want = roman_q.pop_front();
                glyphs_checked++;
                if (char_code !== want.ch)
                    report_error($sformatf("value %0d: char 0x%02h, expected 0x%02h",
                                           want.src, char_code, want.ch));
                if (last !== want.last)
                    report_error($sformatf("value %0d: last %0b, expected %0b",
                                           want.src, last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL integer_to_roman_numeral");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        in_idle_en <= 1'b1;
        out_idle_en <= 1'b1;
        test_directed();
        test_random(200);
        test_backpressure();
        test_steady(40);
        in_valid <= 1'b0;
        while (roman_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Converted %0d values (%0d negative, %0d zero, %0d out of range)",
                 items_sent, neg_items, zero_items, big_items);
        $display("Checked %0d characters, %0d mismatches", glyphs_checked, errors);
        if (errors == 0)
            $display("PASS integer_to_roman_numeral");
        else
            $display("FAIL integer_to_roman_numeral");
        $finish;
    end

endmodule
